// ===== rtl/core/nnts_pkg.sv =====
// shared constants and types for the nearest neighbor table search unit
`default_nettype none
package nnts_pkg;

  localparam int NNTS_TABLE_ENTRIES = 64;
  localparam int NNTS_FEATURES      = 8;

  localparam int VAL_W    = 24;
  localparam int DIFF_W   = VAL_W + 1;
  localparam int SQ_W     = 2 * VAL_W + 1;
  localparam int DIST_W   = 53;
  localparam int POS_W    = 3 * VAL_W;
  localparam int ENT_W    = 6;
  localparam int ELEM_W   = 3;
  localparam int KIND_W   = 2;
  localparam int CFG_AW   = 1;
  localparam int CFG_DW   = 7;
  localparam int EIU_W    = 7;
  localparam int FIU_W    = 4;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic [KIND_W-1:0] KIND_FEATURE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POSITION = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY    = 2'd2;

  localparam logic [CFG_AW-1:0] CFG_ENTRIES  = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_FEATURES = 1'b1;

  // control that travels with each feature beat through the distance pipeline
  typedef struct packed {
    logic valid;
    logic first_feat;
    logic last_feat;
    logic first_entry;
    logic last_entry;
  } tag_t;

endpackage
`default_nettype wire

// ===== rtl/core/nearest_neighbor_table_search_unit.sv =====
// top level: config registers, search sequencer and result port
// A query element with last set starts a search; busy is high from the next cycle until the
// result strobe. The search streams one table feature word per cycle from the feature memory
// through a single subtract/square/accumulate unit. Table and query writes are accepted only
// while busy is low. The result is valid on the best_* ports for the one cycle that done is
// high and is held there until the next search updates it; there is no way to hold it off.
`default_nettype none
module nearest_neighbor_table_search_unit import nnts_pkg::*; #(
  parameter int TABLE_ENTRIES = NNTS_TABLE_ENTRIES,
  parameter int FEATURES      = NNTS_FEATURES
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_AW-1:0]       cfg_addr,
  input  wire logic [CFG_DW-1:0]       cfg_wdata,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [KIND_W-1:0]       kind,
  input  wire logic [ENT_W-1:0]        entry_index,
  input  wire logic [ELEM_W-1:0]       element_index,
  input  wire logic signed [VAL_W-1:0] value,
  input  wire logic signed [VAL_W-1:0] pos_x,
  input  wire logic signed [VAL_W-1:0] pos_y,
  input  wire logic signed [VAL_W-1:0] pos_z,
  input  wire logic                    last,
  output logic                         done,
  output logic signed [VAL_W-1:0]      best_x,
  output logic signed [VAL_W-1:0]      best_y,
  output logic signed [VAL_W-1:0]      best_z,
  output logic [ENT_W-1:0]             best_index,
  output logic [DIST_W-1:0]            best_distance
);

  localparam int MEM_DEPTH = TABLE_ENTRIES * FEATURES;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int EIW       = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int FIW       = (FEATURES > 1) ? $clog2(FEATURES) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_READ  = 2'd3;

  logic [1:0]       state;
  logic [EIU_W-1:0] entries_in_use;
  logic [FIU_W-1:0] features_in_use;
  logic [EIW-1:0]   e, ent_last, ent_last_next;
  logic [FIW-1:0]   f, feat_last, feat_last_next;
  logic [AW-1:0]    base;
  logic             accepted, go;
  tag_t             tag;
  logic             search_done;
  logic [EIW-1:0]   best_idx;
  logic [POS_W-1:0] pos_rd;
  logic signed [VAL_W-1:0] feat_rd, query_rd;

  assign busy     = state != ST_IDLE;
  assign done     = state == ST_READ;
  assign accepted = start && !busy;
  assign go       = accepted && kind == KIND_QUERY && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use  <= EIU_W'(64);
      features_in_use <= FIU_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ENTRIES:  entries_in_use  <= cfg_wdata[EIU_W-1:0];
        CFG_FEATURES: features_in_use <= cfg_wdata[FIU_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the configured counts to the table shape
  always_comb begin
    int n_ent;
    int n_feat;
    n_ent  = int'(entries_in_use);
    n_feat = int'(features_in_use);
    if (n_ent < 1) n_ent = 1;
    if (n_ent > TABLE_ENTRIES) n_ent = TABLE_ENTRIES;
    if (n_feat < 1) n_feat = 1;
    if (n_feat > FEATURES) n_feat = FEATURES;
    ent_last_next  = EIW'(n_ent - 1);
    feat_last_next = FIW'(n_feat - 1);
  end

  always_comb begin
    tag.valid       = state == ST_ISSUE;
    tag.first_feat  = f == '0;
    tag.last_feat   = f == feat_last;
    tag.first_entry = e == '0;
    tag.last_entry  = e == ent_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (go) state <= ST_ISSUE;
        end
        ST_ISSUE: begin
          if (tag.last_feat && tag.last_entry) state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (search_done) state <= ST_READ;
        end
        ST_READ: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      e         <= '0;
      f         <= '0;
      base      <= '0;
      ent_last  <= ent_last_next;
      feat_last <= feat_last_next;
    end else if (state == ST_ISSUE) begin
      if (tag.last_feat) begin
        f    <= '0;
        e    <= e + 1'b1;
        base <= base + AW'(FEATURES);
      end else begin
        f <= f + 1'b1;
      end
    end
  end

  nnts_store #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .FEATURES      (FEATURES)
  ) u_store (
    .clk           (clk),
    .wr_en         (accepted),
    .kind          (kind),
    .entry_index   (entry_index),
    .element_index (element_index),
    .value         (value),
    .pos_wdata     ({pos_x, pos_y, pos_z}),
    .feat_rd_en    (tag.valid),
    .feat_rd_addr  (base + AW'(f)),
    .query_rd_idx  (f),
    .feat_rd       (feat_rd),
    .query_rd      (query_rd),
    .pos_rd_en     (search_done),
    .pos_rd_idx    (best_idx),
    .pos_rd        (pos_rd)
  );

  nnts_dist_unit #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dist (
    .clk         (clk),
    .rst         (rst),
    .tag_in      (tag),
    .feat_rd     (feat_rd),
    .query_rd    (query_rd),
    .search_done (search_done),
    .best_idx    (best_idx),
    .best_dist   (best_distance)
  );

  assign best_x     = pos_rd[3*VAL_W-1:2*VAL_W];
  assign best_y     = pos_rd[2*VAL_W-1:VAL_W];
  assign best_z     = pos_rd[VAL_W-1:0];
  assign best_index = ENT_W'(best_idx);

endmodule
`default_nettype wire

// ===== rtl/core/nnts_store.sv =====
// feature memory, query registers and position memory
`default_nettype none
module nnts_store import nnts_pkg::*; #(
  parameter int TABLE_ENTRIES = NNTS_TABLE_ENTRIES,
  parameter int FEATURES      = NNTS_FEATURES,
  localparam int MEM_DEPTH    = TABLE_ENTRIES * FEATURES,
  localparam int AW           = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1,
  localparam int EIW          = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  localparam int FIW          = (FEATURES > 1) ? $clog2(FEATURES) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    wr_en,
  input  wire logic [KIND_W-1:0]       kind,
  input  wire logic [ENT_W-1:0]        entry_index,
  input  wire logic [ELEM_W-1:0]       element_index,
  input  wire logic signed [VAL_W-1:0] value,
  input  wire logic [POS_W-1:0]        pos_wdata,
  input  wire logic                    feat_rd_en,
  input  wire logic [AW-1:0]           feat_rd_addr,
  input  wire logic [FIW-1:0]          query_rd_idx,
  output logic signed [VAL_W-1:0]      feat_rd,
  output logic signed [VAL_W-1:0]      query_rd,
  input  wire logic                    pos_rd_en,
  input  wire logic [EIW-1:0]          pos_rd_idx,
  output logic [POS_W-1:0]             pos_rd
);

  logic signed [VAL_W-1:0] feat_mem [MEM_DEPTH];
  logic [POS_W-1:0]        pos_mem [TABLE_ENTRIES];
  logic signed [VAL_W-1:0] query [FEATURES];

  logic          entry_ok;
  logic          elem_ok;
  logic [AW-1:0] feat_wr_addr;

  assign entry_ok     = int'(entry_index) < TABLE_ENTRIES;
  assign elem_ok      = int'(element_index) < FEATURES;
  assign feat_wr_addr = AW'(int'(entry_index) * FEATURES + int'(element_index));

  always_ff @(posedge clk) begin
    if (wr_en && kind == KIND_FEATURE && entry_ok && elem_ok) begin
      feat_mem[feat_wr_addr] <= value;
    end
    if (feat_rd_en) begin
      feat_rd <= feat_mem[feat_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && kind == KIND_POSITION && entry_ok) begin
      pos_mem[EIW'(entry_index)] <= pos_wdata;
    end
    if (pos_rd_en) begin
      pos_rd <= pos_mem[pos_rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && kind == KIND_QUERY && elem_ok) begin
      query[FIW'(element_index)] <= value;
    end
    if (feat_rd_en) begin
      query_rd <= query[query_rd_idx];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/nnts_dist_unit.sv =====
// shared subtract, square and saturating accumulate unit with running minimum
`default_nettype none
module nnts_dist_unit import nnts_pkg::*; #(
  parameter int TABLE_ENTRIES = NNTS_TABLE_ENTRIES,
  localparam int EIW          = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire tag_t                    tag_in,
  input  wire logic signed [VAL_W-1:0] feat_rd,
  input  wire logic signed [VAL_W-1:0] query_rd,
  output logic                         search_done,
  output logic [EIW-1:0]               best_idx,
  output logic [DIST_W-1:0]            best_dist
);

  tag_t                     t1, t2, t3;
  logic signed [DIFF_W-1:0] diff;
  logic [SQ_W-1:0]          sq;
  logic [DIST_W-1:0]        acc;
  logic [DIST_W:0]          sum;
  logic                     dv, d_first, d_last;
  logic [EIW-1:0]           cnt;
  logic [EIW-1:0]           cur_idx;
  logic signed [2*DIFF_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1 <= '0;
      t2 <= '0;
      t3 <= '0;
    end else begin
      t1 <= tag_in;
      t2 <= t1;
      t3 <= t2;
    end
  end

  assign prod = diff * diff;
  assign sum  = {1'b0, acc} + (DIST_W + 1)'(sq);

  always_ff @(posedge clk) begin
    diff <= DIFF_W'(feat_rd) - DIFF_W'(query_rd);
    sq   <= SQ_W'(prod);
    if (t3.valid) begin
      if (t3.first_feat) begin
        acc <= DIST_W'(sq);
      end else if (sum[DIST_W]) begin
        acc <= DIST_MAX;
      end else begin
        acc <= sum[DIST_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= 1'b0;
    end else begin
      dv <= t3.valid && t3.last_feat;
    end
    d_first <= t3.first_entry;
    d_last  <= t3.last_entry;
  end

  assign cur_idx = d_first ? '0 : cnt + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_done <= 1'b0;
    end else begin
      search_done <= dv && d_last;
    end
    if (dv) begin
      cnt <= cur_idx;
      if (d_first || acc < best_dist) begin
        best_dist <= acc;
        best_idx  <= cur_idx;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/nnts_checker.sv =====
// port-level checks for the search unit, bound to the top level
`default_nettype none
module nnts_checker import nnts_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire logic [KIND_W-1:0] kind,
  input wire logic              last
);

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe outside a search");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one beat");

  a_go_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && kind == KIND_QUERY && last |=> busy)
    else $error("search did not start");

  a_no_search: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !(kind == KIND_QUERY && last) |=> !busy)
    else $error("write beat left the unit busy");

  a_end_result: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> $past(done))
    else $error("search ended without a result");

endmodule

bind nearest_neighbor_table_search_unit nnts_checker u_chk (.*);
`default_nettype wire
